// ===== sv/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, types and a rotate function.
// No dependencies.
package sha_pkg;

  localparam int QueueDepth = 4;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_LEN, ST_EMIT
  } sha_state_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

endpackage

// ===== sv/sha256_stream_hasher.sv =====
// SHA-256 stream hasher, one message byte per input transfer, eight digest
// word transfers per message out. A byte that fills a block holds the round
// engine for a load, 64 rounds on one shared round unit and a fold; other
// bytes are only stored. The final item also runs the padding block, and a
// second block when the length needs one, then eight digest words are
// offered and the engine takes no new item until the eighth is transferred.
// A queue of Depth entries (four by default) sits between the front end and
// the round engine, so input keeps flowing during compression until it fills.
module sha256_stream_hasher import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        no_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  logic      q_valid, q_take;
  sha_item_t q_item;

  sha_front #(.Depth(Depth)) u_front (
    .clk, .rst, .push, .full, .data_byte, .is_last, .no_byte,
    .q_valid, .q_item, .q_take
  );

  sha_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_take,
    .empty, .pop, .digest_word, .word_index, .last_word
  );

`ifndef SYNTHESIS
  // The final digest word always carries index seven.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && last_word) |-> (word_index == 3'd7))
    else $error("last_word without index seven");

  // After the last word is taken, no further result is offered next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last_word) |=> empty)
    else $error("result after final digest word");

  // A waiting word that is not taken keeps its index.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (empty || $stable(word_index)))
    else $error("digest index moved while stalled");
`endif
endmodule

// ===== sv/sha_front.sv =====
// Front end of the SHA-256 hasher: takes byte items, drops empty non-last ones,
// and queues the rest for the compression engine. Depends on sha_pkg.
module sha_front import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  logic [7:0] data_byte,
  input  logic      is_last,
  input  logic      no_byte,
  output logic      q_valid,
  output sha_item_t q_item,
  input  logic      q_take
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_item_t       mem [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop, keep;

  assign full    = (count == (AW+1)'(Depth));
  assign keep    = !no_byte || is_last;
  assign do_push = push && !full && keep;
  assign q_valid = (count != '0);
  assign do_pop  = q_take && q_valid;
  assign q_item  = mem[rd_ptr];

  // Store the classified item.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{data_byte: data_byte, has_byte: !no_byte, is_last: is_last};
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== sv/sha_back.sv =====
// Back end of the SHA-256 hasher: block buffer, schedule, one round per cycle,
// padding and digest output. Depends on sha_pkg.
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  sha_item_t   q_item,
  output logic        q_take,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha_state_t  state, state_next;
  logic [31:0] hv [8];
  logic [31:0] r  [8];
  logic [31:0] w  [16];
  logic [60:0] byte_count;
  logic [5:0]  rnd;
  logic        fin;       // last item of the message has been taken
  logic        padded;    // pad byte already placed for this message
  logic        len_fits;  // length goes into the current padded block
  logic [2:0]  out_idx;

  logic [5:0]  pos;
  logic [31:0] s0, s1, w_new, sig0, sig1, ch, maj, t1;
  logic        start_block;
  logic        full_block;
  logic        len_room;

  // Insert a byte into its lane; the first lane of a word clears the word.
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] res;
    case (lane)
      2'd0:    res = {b, 24'd0};
      2'd1:    res = {word[31:24], b, word[15:0]};
      2'd2:    res = {word[31:16], b, word[7:0]};
      default: res = {word[31:8], b};
    endcase
    return res;
  endfunction

  assign pos      = byte_count[5:0];
  assign len_room = (pos < 6'd56);

  // Round datapath.
  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    sig1  = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
    ch    = (r[4] & r[5]) ^ (~r[4] & r[6]);
    t1    = r[7] + sig1 + ch + ROUND_K[rnd] + w[0];
    sig0  = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
    maj   = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
  end

  assign q_take      = (state == ST_LOAD) && q_valid;
  assign empty       = (state != ST_EMIT);
  assign digest_word = hv[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);
  assign full_block  = q_item.has_byte && (pos == 6'd63);
  assign start_block = q_take && (full_block || q_item.is_last);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (start_block) state_next =
                  (q_item.is_last && !full_block) ? ST_PAD : ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD:  state_next = fin ? (padded ? (len_fits ? ST_EMIT : ST_LEN) : ST_PAD)
                                 : ST_LOAD;
      ST_PAD:   state_next = ST_ROUND;
      ST_LEN:   state_next = ST_ROUND;
      ST_EMIT:  if (pop && out_idx == 3'd7) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      rnd        <= '0;
      fin        <= 1'b0;
      padded     <= 1'b0;
      len_fits   <= 1'b0;
      out_idx    <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        ST_LOAD: if (q_take) begin
          if (q_item.has_byte) begin
            byte_count <= byte_count + 61'd1;
            w[pos[5:2]] <= put_byte(w[pos[5:2]], pos[1:0], q_item.data_byte);
          end
          fin    <= q_item.is_last;
          padded <= 1'b0;
          for (int i = 0; i < 8; i++) r[i] <= hv[i];
          rnd <= '0;
        end
        ST_PAD: begin
          // Append the pad byte, clear the rest and place the length if it fits.
          for (int i = 0; i < 16; i++) begin
            if (i == int'(pos[5:2])) w[i] <= put_byte(w[i], pos[1:0], PAD_BYTE);
            else if (i == 14 && len_room) w[i] <= byte_count[60:29];
            else if (i == 15 && len_room) w[i] <= {byte_count[28:0], 3'b000};
            else if (i > int'(pos[5:2])) w[i] <= '0;
          end
          len_fits <= len_room;
          padded   <= 1'b1;
          for (int i = 0; i < 8; i++) r[i] <= hv[i];
          rnd <= '0;
        end
        ST_LEN: begin
          for (int i = 0; i < 14; i++) w[i] <= '0;
          w[14] <= byte_count[60:29];
          w[15] <= {byte_count[28:0], 3'b000};
          for (int i = 0; i < 8; i++) r[i] <= hv[i];
          rnd <= '0;
          fin <= 1'b1;
          len_fits <= 1'b1;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4];
          r[4] <= r[3] + t1;
          r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0];
          r[0] <= t1 + sig0 + maj;
          rnd  <= rnd + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + r[i];
          out_idx <= '0;
        end
        ST_EMIT: if (pop) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            byte_count <= '0;
            for (int i = 0; i < 8; i++) hv[i] <= INIT_HASH[i];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/sha256_stream_hasher_test.sv =====
// Self-checking testbench for sha256_stream_hasher: byte messages in, digest words out.
// Depends on sha_pkg and the RTL of the hasher. Expected digests come from an
// in-bench SHA-256 calculation, or from known digests for a few directed messages.
module sha256_stream_hasher_test;
  import sha_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 100;
  localparam int DirectedRows = 10;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         is_last;
    logic         no_byte;
    logic         known;
    logic [255:0] digest;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // Directed messages: empty, "abc", extremes, a last item without a byte
  localparam msg_item_t DirectedTable [DirectedRows] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, EmptyDigest},
    '{8'h5a, 1'b0, 1'b1, 1'b0, 256'd0},
    '{8'h61, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'h62, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'h63, 1'b1, 1'b0, 1'b1, AbcDigest},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        no_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  msg_item_t    msg_items [$];
  digest_word_t digest_q [$];
  int           send_idx = 0;
  int           hold_cycles = 0;
  bit           hold_done = 1'b0;
  bit           failed = 1'b0;
  int           cycles = 0;

  // Hash state of the bench copy
  logic [31:0] chain [8];
  logic [31:0] blk_words [16];
  logic [60:0] byte_cnt;

  sha256_stream_hasher dut (
    .clk, .rst, .push, .full, .data_byte, .is_last, .no_byte,
    .empty, .pop, .digest_word, .word_index, .last_word
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Append one item to the stimulus list
  function automatic void add_item(input msg_item_t it);
    msg_items.insert(msg_items.size(), it);
  endfunction

  function automatic void hash_reset();
    for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    byte_cnt = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + w[i];
      t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += r[i];
  endfunction

  function automatic void place_byte(input int pos, input logic [7:0] b);
    int wi;
    int sh;
    wi = pos / 4;
    sh = (3 - pos % 4) * 8;
    if (pos % 4 == 0) blk_words[wi] = 32'(b) << sh;
    else blk_words[wi] |= 32'(b) << sh;
  endfunction

  // Advance the bench hash on one accepted transfer; queue the digest on the last item
  function automatic void hash_item(input msg_item_t it);
    int pos;
    logic [63:0] bits;
    digest_word_t dw;
    if (!it.no_byte) begin
      pos = int'(byte_cnt[5:0]);
      place_byte(pos, it.data_byte);
      byte_cnt = byte_cnt + 1'b1;
      if (pos == 63) compress();
    end
    if (!it.is_last) return;
    pos = int'(byte_cnt[5:0]);
    place_byte(pos, PAD_BYTE);
    for (int i = pos / 4 + 1; i < 16; i++) blk_words[i] = '0;
    if (pos >= 56) begin
      compress();
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
    end
    bits = {byte_cnt, 3'b000};
    blk_words[14] = bits[63:32];
    blk_words[15] = bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      dw = '{it.known ? it.digest[255 - 32*i -: 32] : chain[i], 3'(i), i == 7};
      digest_q.insert(digest_q.size(), dw);
    end
    hash_reset();
  endfunction

  // Build the directed rows, then random messages of mostly small sizes
  initial begin
    int len;
    int n;
    msg_item_t it;
    hash_reset();
    for (int i = 0; i < DirectedRows; i++) add_item(DirectedTable[i]);
    n = 0;
    while (n < RandomItems) begin
      if ($urandom_range(3) == 0) len = $urandom_range(55, 130);
      else len = $urandom_range(0, 12);
      if (len > RandomItems - n) len = RandomItems - n;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(9) == 0)
          add_item('{8'($urandom), 1'b0, 1'b1, 1'b0, 256'd0});
        it = '{8'($urandom), (j == len - 1), 1'b0, 1'b0, 256'd0};
        // sometimes close the message with a separate item that carries no byte
        if (j == len - 1 && $urandom_range(3) == 0) begin
          it.is_last = 1'b0;
          add_item(it);
          it = '{8'($urandom), 1'b1, 1'b1, 1'b0, 256'd0};
        end
        add_item(it);
      end
      if (len == 0) add_item('{8'($urandom), 1'b1, 1'b1, 1'b0, 256'd0});
      n += (len == 0) ? 1 : len;
    end
  end

  function automatic int idle_pct(input bit sender);
    int phase;
    phase = send_idx * 3 / (msg_items.size() + 1);
    if (phase == 0) return sender ? 28 : 50;
    if (phase == 1) return sender ? 50 : 28;
    return 0;
  endfunction

  // Sender: offer items, hold on full, advance on transfer
  always @(posedge clk) begin
    bit accepted;
    if (rst) begin
      push <= 1'b0;
    end else begin
      accepted = push && !full;
      if (accepted) begin
        hash_item(msg_items[send_idx]);
        send_idx++;
      end
      if (!push || accepted) begin
        if (send_idx < msg_items.size() && $urandom_range(99) >= idle_pct(1'b1)) begin
          push <= 1'b1;
          data_byte <= msg_items[send_idx].data_byte;
          is_last <= msg_items[send_idx].is_last;
          no_byte <= msg_items[send_idx].no_byte;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each digest word transfer; hold off once for a long stretch
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", digest_word);
          failed = 1'b1;
        end else begin
          exp_w = digest_q.pop_front();
          if (digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, digest_word);
            failed = 1'b1;
          end
          if (word_index !== exp_w.index) begin
            $error("word_index expected %0d actual %0d", exp_w.index, word_index);
            failed = 1'b1;
          end
          if (last_word !== exp_w.last) begin
            $error("last_word expected %0d actual %0d", exp_w.last, last_word);
            failed = 1'b1;
          end
        end
      end
      if (!hold_done && send_idx >= DirectedRows + 20) begin
        hold_done = 1'b1;
        hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= idle_pct(1'b0));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (msg_items.size() > 0 && send_idx == msg_items.size() && digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (!failed && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_back.sv
sv/sha256_stream_hasher.sv
tb/sha256_stream_hasher_test.sv
